### hw/rtl/scci_pkg.sv
// ----------------------------------------------------------------------------
// scci_pkg: shared types and constants of the swept circle contact engine
// Widths of every internal quantity follow from the coordinate width and the
// number of fraction bits; word types for both channels and the cell rows.
// ----------------------------------------------------------------------------
package scci_pkg;

	// Fraction bits of the time results.
	localparam int FRAC_BITS = 16;

	localparam int CRD_W = 32;
	localparam int RAD_W = 31;
	localparam int T_W = 32;

	localparam int DIF_W = CRD_W + 1;
	localparam int VEL_W = CRD_W + 2;
	localparam int RS_W = RAD_W + 1;
	localparam int A_W = 2 * VEL_W;
	localparam int HALF_W = A_W / 2;
	localparam int D_W = 2 * A_W + 1;
	localparam int RDX_W = 2 * A_W - 2;
	localparam int ROOT_W = RDX_W / 2 + FRAC_BITS;
	localparam int RADC_W = 2 * ROOT_W;
	localparam int RREM_W = ROOT_W + 2;
	localparam int NB_W = A_W + FRAC_BITS + 1;
	localparam int NUM_W = NB_W + 1;
	localparam int DIV_W = A_W + T_W;
	localparam int CMP_W = (NUM_W > DIV_W) ? NUM_W : DIV_W;

	localparam logic signed [T_W-1:0] T_MAX = {1'b0, {(T_W-1){1'b1}}};
	localparam logic signed [T_W-1:0] T_MIN = {1'b1, {(T_W-1){1'b0}}};

	typedef enum logic [1:0] {
		ST_HIT   = 2'd0,
		ST_MISS  = 2'd1,
		ST_STILL = 2'd2
	} status_t;

	typedef logic signed [DIF_W-1:0] dif_t;
	typedef logic signed [VEL_W-1:0] vel_t;
	typedef logic [RS_W-1:0] rs_t;
	typedef logic signed [A_W-1:0] prd_t;
	typedef logic [A_W-1:0] mag_t;
	typedef logic [2*HALF_W-1:0] pp_t;
	typedef logic [2*A_W-1:0] wide_t;
	typedef logic signed [D_W-1:0] dval_t;
	typedef logic signed [NB_W-1:0] nb_t;
	typedef logic signed [NUM_W-1:0] num_t;
	typedef logic [CMP_W-1:0] cmp_t;
	typedef logic [DIV_W-1:0] dvw_t;
	typedef logic signed [T_W-1:0] tval_t;

	typedef struct packed {
		logic signed [CRD_W-1:0] a_start_x;
		logic signed [CRD_W-1:0] a_start_y;
		logic signed [CRD_W-1:0] a_end_x;
		logic signed [CRD_W-1:0] a_end_y;
		logic signed [CRD_W-1:0] b_start_x;
		logic signed [CRD_W-1:0] b_start_y;
		logic signed [CRD_W-1:0] b_end_x;
		logic signed [CRD_W-1:0] b_end_y;
		logic [RAD_W-1:0]        a_radius;
		logic [RAD_W-1:0]        b_radius;
	} pair_t;

	typedef struct packed {
		status_t                 status;
		logic signed [T_W-1:0]   entry_time;
		logic signed [T_W-1:0]   exit_time;
	} contact_t;

	// One stage of the square root row.
	typedef struct packed {
		logic              valid;
		status_t           status;
		logic [A_W-1:0]    a;
		nb_t               nb;
		logic [RADC_W-1:0] rad;
		logic [RREM_W-1:0] rem;
		logic [ROOT_W-1:0] root;
	} sq_st_t;

	// One quotient lane of the divider row.
	typedef struct packed {
		dvw_t           rem;
		logic [T_W-1:0] q;
		logic           neg;
		logic           ovf;
	} div_lane_t;

	typedef struct packed {
		logic      valid;
		status_t   status;
		dvw_t      den;
		div_lane_t ent;
		div_lane_t ext;
	} div_st_t;

endpackage

### hw/rtl/swept_circle_contact_interval.sv
// ----------------------------------------------------------------------------
// swept_circle_contact_interval: entry and exit time of two moving circles
// Fully pipelined solver of |d + t*v| = rA + rB over one time step.
// ----------------------------------------------------------------------------
// The block takes one word per clock cycle while the pipe is not halted and
// returns one result word per input word, in order, through the front,
// square root, setup, divider and output stages. The latency is set by the
// square root row, one cell per root bit, and by the divider row, one cell
// per bit of the 32-bit time. The whole pipeline moves together: it halts
// only while a finished word waits at the output and the receiver stalls,
// so pair_stall follows contact_stall combinationally in that case.
//
// Each word carries the start and end centers of both circles and their
// radii. The front section forms d and v, the coefficients a = |v|^2,
// b = d.v and c = |d|^2 - R^2, and the discriminant D = b^2 - a*c, all as
// exact integers. A row of square root cells then extracts
// s = floor(sqrt(D * 2^(2*FRAC_BITS))) one bit per cell. Two quotient lanes
// in a row of divider cells work out floor((-b*2^FRAC_BITS -/+ s) / a), the
// entry and exit times, after an overflow test against a*2^32. Times round
// toward minus infinity and saturate to the signed 32-bit range. A word with
// no relative motion reports status ST_STILL, a negative discriminant reports
// ST_MISS, and both give zero times. Nothing is kept between words.
// ----------------------------------------------------------------------------
module swept_circle_contact_interval (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pair_valid,
	output logic               pair_stall,
	input  scci_pkg::pair_t    pair,
	output logic               contact_valid,
	input  logic               contact_stall,
	output scci_pkg::contact_t contact
);

	logic adv;

	scci_pkg::sq_st_t  sq_chain [scci_pkg::ROOT_W+1];
	scci_pkg::div_st_t div_chain [scci_pkg::T_W+1];
	scci_pkg::sq_st_t  sq_end;
	scci_pkg::div_st_t div_end;

	// Division setup stages.
	logic              vld_s1, vld_s2, vld_s3;
	scci_pkg::status_t stat_s1, stat_s2;
	scci_pkg::mag_t    a_s1, a_s2;
	scci_pkg::num_t    ne_s1, nx_s1;
	scci_pkg::cmp_t    me_s2, mx_s2;
	logic              neg_e_s2, neg_x_s2;
	scci_pkg::div_st_t dv_c, dat_s3, dv0;

	scci_pkg::contact_t res_c;
	scci_pkg::contact_t ctc_q;
	logic               out_vld_q;

	// The pipe moves unless a finished word is held by the receiver.
	assign adv           = !out_vld_q || !contact_stall;
	assign pair_stall    = !adv;
	assign contact_valid = out_vld_q;
	assign contact       = ctc_q;

	scci_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.pair_valid (pair_valid),
		.pair       (pair),
		.st         (sq_chain[0])
	);

	for (genvar g = 0; g < scci_pkg::ROOT_W; g++) begin : g_sq
		scci_sqrt_cell u_sq (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.d      (sq_chain[g]),
			.q      (sq_chain[g+1])
		);
	end

	assign sq_end = sq_chain[scci_pkg::ROOT_W];

	// The entry numerator takes the minus root and the exit numerator the plus
	// root. The magnitudes feed the divider; the sign sets the rounding later.
	always_comb begin
		dv_c            = '0;
		dv_c.valid      = vld_s2;
		dv_c.status     = stat_s2;
		dv_c.den        = scci_pkg::dvw_t'(a_s2) << (scci_pkg::T_W - 1);
		dv_c.ent.rem    = me_s2[scci_pkg::DIV_W-1:0];
		dv_c.ent.q      = '0;
		dv_c.ent.neg    = neg_e_s2;
		dv_c.ent.ovf    = ((me_s2 >> scci_pkg::T_W) >= scci_pkg::cmp_t'(a_s2));
		dv_c.ext.rem    = mx_s2[scci_pkg::DIV_W-1:0];
		dv_c.ext.q      = '0;
		dv_c.ext.neg    = neg_x_s2;
		dv_c.ext.ovf    = ((mx_s2 >> scci_pkg::T_W) >= scci_pkg::cmp_t'(a_s2));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= sq_end.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			stat_s1 <= sq_end.status;
			a_s1    <= sq_end.a;
			ne_s1   <= scci_pkg::num_t'(sq_end.nb) - scci_pkg::num_t'(sq_end.root);
			nx_s1   <= scci_pkg::num_t'(sq_end.nb) + scci_pkg::num_t'(sq_end.root);

			stat_s2  <= stat_s1;
			a_s2     <= a_s1;
			neg_e_s2 <= ne_s1[scci_pkg::NUM_W-1];
			neg_x_s2 <= nx_s1[scci_pkg::NUM_W-1];
			me_s2    <= scci_pkg::cmp_t'(ne_s1[scci_pkg::NUM_W-1] ? -ne_s1 : ne_s1);
			mx_s2    <= scci_pkg::cmp_t'(nx_s1[scci_pkg::NUM_W-1] ? -nx_s1 : nx_s1);

			dat_s3 <= dv_c;
		end
	end

	always_comb begin
		dv0       = dat_s3;
		dv0.valid = vld_s3;
	end

	assign div_chain[0] = dv0;

	for (genvar g = 0; g < scci_pkg::T_W; g++) begin : g_div
		scci_div_cell u_div (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.d      (div_chain[g]),
			.q      (div_chain[g+1])
		);
	end

	assign div_end = div_chain[scci_pkg::T_W];

	// A negative numerator rounds its magnitude up before the sign goes back.
	function automatic scci_pkg::tval_t sat_time(input scci_pkg::div_lane_t l);
		logic [scci_pkg::T_W:0] qc;
		scci_pkg::tval_t        r;
		qc = {1'b0, l.q} + {{scci_pkg::T_W{1'b0}}, |l.rem};
		if (!l.neg) begin
			r = (l.ovf || l.q[scci_pkg::T_W-1]) ? scci_pkg::T_MAX : scci_pkg::tval_t'(l.q);
		end else if (l.ovf || (qc > {1'b0, scci_pkg::T_MIN})) begin
			r = scci_pkg::T_MIN;
		end else begin
			r = scci_pkg::tval_t'(-qc[scci_pkg::T_W-1:0]);
		end
		return r;
	endfunction

	always_comb begin
		res_c.status = div_end.status;
		if (div_end.status == scci_pkg::ST_HIT) begin
			res_c.entry_time = sat_time(div_end.ent);
			res_c.exit_time  = sat_time(div_end.ext);
		end else begin
			res_c.entry_time = '0;
			res_c.exit_time  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= div_end.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctc_q <= res_c;
		end
	end

	// A hit interval never closes before it opens.
	ap_order: assert property (@(posedge clk) disable iff (!arst_n)
		contact_valid && (contact.status == scci_pkg::ST_HIT)
		|-> (contact.entry_time <= contact.exit_time))
		else $error("entry time after exit time");

	// Words that are not hits carry zero times.
	ap_zero: assert property (@(posedge clk) disable iff (!arst_n)
		contact_valid && (contact.status != scci_pkg::ST_HIT)
		|-> (contact.entry_time == '0) && (contact.exit_time == '0))
		else $error("nonzero time on a miss or still word");

	// The square root remainder stays within twice the root.
	ap_root: assert property (@(posedge clk) disable iff (!arst_n)
		sq_end.valid && (sq_end.status == scci_pkg::ST_HIT)
		|-> (sq_end.rem <= {1'b0, sq_end.root, 1'b0}))
		else $error("square root remainder out of range");

	// A halted pipe keeps the divider input word.
	ap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv && div_chain[0].valid |=> $stable(div_chain[0]))
		else $error("divider input changed while halted");

endmodule

### hw/rtl/scci_front.sv
// ----------------------------------------------------------------------------
// scci_front: quadratic coefficients and discriminant
// Seven stages: differences, products, sums, magnitudes, split products,
// product assembly and the discriminant with the status decision.
// ----------------------------------------------------------------------------
module scci_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             pair_valid,
	input  scci_pkg::pair_t  pair,
	output scci_pkg::sq_st_t st
);

	scci_pkg::dif_t dx_c, dy_c, ex_c, ey_c;
	scci_pkg::vel_t vx_c, vy_c;
	scci_pkg::rs_t  rs_c;

	logic           vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	scci_pkg::dif_t dx_s1, dy_s1;
	scci_pkg::vel_t vx_s1, vy_s1;
	scci_pkg::rs_t  rs_s1;

	scci_pkg::prd_t vxx_s2, vyy_s2, dxv_s2, dyv_s2, dxx_s2, dyy_s2;
	logic [2*scci_pkg::RS_W-1:0] rr_s2;

	scci_pkg::mag_t a_s3;
	scci_pkg::prd_t b_s3, c_s3;

	scci_pkg::mag_t a_s4, bm_s4, cm_s4;
	scci_pkg::prd_t b_s4;
	logic           cneg_s4, zero_s4;

	scci_pkg::pp_t  bhh_s5, bhl_s5, bll_s5, ahh_s5, ahl_s5, alh_s5, all_s5;
	scci_pkg::mag_t a_s5;
	scci_pkg::prd_t b_s5;
	logic           cneg_s5, zero_s5;

	scci_pkg::wide_t bsq_s6, ac_s6;
	scci_pkg::mag_t  a_s6;
	scci_pkg::prd_t  b_s6;
	logic            cneg_s6, zero_s6;

	scci_pkg::dval_t   d_c;
	scci_pkg::nb_t     nb_c;
	scci_pkg::status_t stat_c;

	scci_pkg::status_t               stat_s7;
	scci_pkg::mag_t                  a_s7;
	scci_pkg::nb_t                   nb_s7;
	logic [scci_pkg::RADC_W-1:0]     rad_s7;

	// Start separation and relative motion.
	assign dx_c = scci_pkg::dif_t'(pair.b_start_x) - scci_pkg::dif_t'(pair.a_start_x);
	assign dy_c = scci_pkg::dif_t'(pair.b_start_y) - scci_pkg::dif_t'(pair.a_start_y);
	assign ex_c = scci_pkg::dif_t'(pair.b_end_x) - scci_pkg::dif_t'(pair.a_end_x);
	assign ey_c = scci_pkg::dif_t'(pair.b_end_y) - scci_pkg::dif_t'(pair.a_end_y);
	assign vx_c = scci_pkg::vel_t'(ex_c) - scci_pkg::vel_t'(dx_c);
	assign vy_c = scci_pkg::vel_t'(ey_c) - scci_pkg::vel_t'(dy_c);
	assign rs_c = scci_pkg::rs_t'(pair.a_radius) + scci_pkg::rs_t'(pair.b_radius);

	// The discriminant sign picks miss; zero motion overrides everything.
	always_comb begin
		if (cneg_s6) begin
			d_c = scci_pkg::dval_t'(bsq_s6) + scci_pkg::dval_t'(ac_s6);
		end else begin
			d_c = scci_pkg::dval_t'(bsq_s6) - scci_pkg::dval_t'(ac_s6);
		end
		nb_c = -(scci_pkg::nb_t'(b_s6) <<< scci_pkg::FRAC_BITS);
		priority if (zero_s6) begin
			stat_c = scci_pkg::ST_STILL;
		end else if (d_c[scci_pkg::D_W-1]) begin
			stat_c = scci_pkg::ST_MISS;
		end else begin
			stat_c = scci_pkg::ST_HIT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= pair_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1 <= dx_c;
			dy_s1 <= dy_c;
			vx_s1 <= vx_c;
			vy_s1 <= vy_c;
			rs_s1 <= rs_c;

			vxx_s2 <= scci_pkg::prd_t'(vx_s1) * scci_pkg::prd_t'(vx_s1);
			vyy_s2 <= scci_pkg::prd_t'(vy_s1) * scci_pkg::prd_t'(vy_s1);
			dxv_s2 <= scci_pkg::prd_t'(dx_s1) * scci_pkg::prd_t'(vx_s1);
			dyv_s2 <= scci_pkg::prd_t'(dy_s1) * scci_pkg::prd_t'(vy_s1);
			dxx_s2 <= scci_pkg::prd_t'(dx_s1) * scci_pkg::prd_t'(dx_s1);
			dyy_s2 <= scci_pkg::prd_t'(dy_s1) * scci_pkg::prd_t'(dy_s1);
			rr_s2  <= {{scci_pkg::RS_W{1'b0}}, rs_s1} * {{scci_pkg::RS_W{1'b0}}, rs_s1};

			a_s3 <= scci_pkg::mag_t'(vxx_s2 + vyy_s2);
			b_s3 <= dxv_s2 + dyv_s2;
			c_s3 <= dxx_s2 + dyy_s2 - scci_pkg::prd_t'(rr_s2);

			a_s4    <= a_s3;
			b_s4    <= b_s3;
			bm_s4   <= b_s3[scci_pkg::A_W-1] ? scci_pkg::mag_t'(-b_s3) : scci_pkg::mag_t'(b_s3);
			cm_s4   <= c_s3[scci_pkg::A_W-1] ? scci_pkg::mag_t'(-c_s3) : scci_pkg::mag_t'(c_s3);
			cneg_s4 <= c_s3[scci_pkg::A_W-1];
			zero_s4 <= (a_s3 == '0);

			// Half-width partial products of b*b and a*|c|.
			bhh_s5 <= scci_pkg::pp_t'(bm_s4[scci_pkg::A_W-1:scci_pkg::HALF_W])
				* scci_pkg::pp_t'(bm_s4[scci_pkg::A_W-1:scci_pkg::HALF_W]);
			bhl_s5 <= scci_pkg::pp_t'(bm_s4[scci_pkg::A_W-1:scci_pkg::HALF_W])
				* scci_pkg::pp_t'(bm_s4[scci_pkg::HALF_W-1:0]);
			bll_s5 <= scci_pkg::pp_t'(bm_s4[scci_pkg::HALF_W-1:0])
				* scci_pkg::pp_t'(bm_s4[scci_pkg::HALF_W-1:0]);
			ahh_s5 <= scci_pkg::pp_t'(a_s4[scci_pkg::A_W-1:scci_pkg::HALF_W])
				* scci_pkg::pp_t'(cm_s4[scci_pkg::A_W-1:scci_pkg::HALF_W]);
			ahl_s5 <= scci_pkg::pp_t'(a_s4[scci_pkg::A_W-1:scci_pkg::HALF_W])
				* scci_pkg::pp_t'(cm_s4[scci_pkg::HALF_W-1:0]);
			alh_s5 <= scci_pkg::pp_t'(a_s4[scci_pkg::HALF_W-1:0])
				* scci_pkg::pp_t'(cm_s4[scci_pkg::A_W-1:scci_pkg::HALF_W]);
			all_s5 <= scci_pkg::pp_t'(a_s4[scci_pkg::HALF_W-1:0])
				* scci_pkg::pp_t'(cm_s4[scci_pkg::HALF_W-1:0]);
			a_s5    <= a_s4;
			b_s5    <= b_s4;
			cneg_s5 <= cneg_s4;
			zero_s5 <= zero_s4;

			bsq_s6 <= (scci_pkg::wide_t'(bhh_s5) << (2 * scci_pkg::HALF_W))
				+ (scci_pkg::wide_t'(bhl_s5) << (scci_pkg::HALF_W + 1))
				+ scci_pkg::wide_t'(bll_s5);
			ac_s6 <= (scci_pkg::wide_t'(ahh_s5) << (2 * scci_pkg::HALF_W))
				+ (scci_pkg::wide_t'(ahl_s5) << scci_pkg::HALF_W)
				+ (scci_pkg::wide_t'(alh_s5) << scci_pkg::HALF_W)
				+ scci_pkg::wide_t'(all_s5);
			a_s6    <= a_s5;
			b_s6    <= b_s5;
			cneg_s6 <= cneg_s5;
			zero_s6 <= zero_s5;

			stat_s7 <= stat_c;
			a_s7    <= a_s6;
			nb_s7   <= nb_c;
			rad_s7  <= {d_c[scci_pkg::RDX_W-1:0], {(2 * scci_pkg::FRAC_BITS){1'b0}}};
		end
	end

	always_comb begin
		st.valid  = vld_s7;
		st.status = stat_s7;
		st.a      = a_s7;
		st.nb     = nb_s7;
		st.rad    = rad_s7;
		st.rem    = '0;
		st.root   = '0;
	end

endmodule

### hw/rtl/scci_sqrt_cell.sv
// ----------------------------------------------------------------------------
// scci_sqrt_cell: one digit of the integer square root
// Takes two radicand bits, settles one root bit and hands the word on.
// ----------------------------------------------------------------------------
module scci_sqrt_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  scci_pkg::sq_st_t d,
	output scci_pkg::sq_st_t q
);

	logic [scci_pkg::RREM_W-1:0] rem2, trial;
	logic                        ge;
	scci_pkg::sq_st_t            nxt;
	scci_pkg::sq_st_t            dat_q;
	logic                        vld_q;

	assign rem2  = {d.rem[scci_pkg::RREM_W-3:0], d.rad[scci_pkg::RADC_W-1 -: 2]};
	assign trial = {d.root, 2'b01};
	assign ge    = (rem2 >= trial);

	always_comb begin
		nxt      = d;
		nxt.rad  = d.rad << 2;
		nxt.rem  = ge ? (rem2 - trial) : rem2;
		nxt.root = {d.root[scci_pkg::ROOT_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= d.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dat_q <= nxt;
		end
	end

	always_comb begin
		q       = dat_q;
		q.valid = vld_q;
	end

endmodule

### hw/rtl/scci_div_cell.sv
// ----------------------------------------------------------------------------
// scci_div_cell: one quotient bit of both time divisions
// Compares each lane's remainder with the shifted divisor and subtracts.
// ----------------------------------------------------------------------------
module scci_div_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  scci_pkg::div_st_t d,
	output scci_pkg::div_st_t q
);

	scci_pkg::div_st_t nxt;
	scci_pkg::div_st_t dat_q;
	logic              vld_q;

	function automatic scci_pkg::div_lane_t lane_step(input scci_pkg::div_lane_t l,
		input scci_pkg::dvw_t den);
		scci_pkg::div_lane_t r;
		logic                ge;
		ge    = (l.rem >= den);
		r     = l;
		r.rem = ge ? (l.rem - den) : l.rem;
		r.q   = {l.q[scci_pkg::T_W-2:0], ge};
		return r;
	endfunction

	always_comb begin
		nxt     = d;
		nxt.ent = lane_step(d.ent, d.den);
		nxt.ext = lane_step(d.ext, d.den);
		nxt.den = d.den >> 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= d.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dat_q <= nxt;
		end
	end

	always_comb begin
		q       = dat_q;
		q.valid = vld_q;
	end

endmodule

### bench/swept_circle_contact_interval_tb.sv
// ----------------------------------------------------------------------------
// swept_circle_contact_interval_tb: self-checking bench of the contact solver
// Drives pairs of moving circles, predicts status, entry and exit time with
// exact wide integer arithmetic, and compares every result word in order.
// ----------------------------------------------------------------------------
module swept_circle_contact_interval_tb;

	// Wide enough for D * 2^(2*FRAC_BITS) with sign margin.
	typedef logic signed [319:0] big_t;

	// Keeps the expected contact words in order and counts mismatches.
	class contact_board;
		scci_pkg::contact_t pending[$];
		int errors;

		function automatic big_t isqrt(big_t v);
			big_t r;
			big_t cand;
			r = 0;
			for (int i = 159; i >= 0; i--) begin
				cand = r | (big_t'(1) <<< i);
				if (cand * cand <= v)
					r = cand;
			end
			return r;
		endfunction

		// Floor division by a positive divisor, then clamp to 32 bits.
		function automatic scci_pkg::tval_t floor_div_sat(big_t num, big_t den);
			big_t q;
			q = num / den;
			if (num < 0 && q * den != num)
				q = q - 1;
			if (q > big_t'(scci_pkg::T_MAX))
				return scci_pkg::T_MAX;
			if (q < big_t'(scci_pkg::T_MIN))
				return scci_pkg::T_MIN;
			return scci_pkg::tval_t'(q);
		endfunction

		function automatic void note_pair(scci_pkg::pair_t p);
			big_t dx, dy, vx, vy, rs, ca, cb, cc, disc, s, nb;
			scci_pkg::contact_t e;
			dx = big_t'(p.b_start_x) - big_t'(p.a_start_x);
			dy = big_t'(p.b_start_y) - big_t'(p.a_start_y);
			vx = (big_t'(p.b_end_x) - big_t'(p.a_end_x)) - dx;
			vy = (big_t'(p.b_end_y) - big_t'(p.a_end_y)) - dy;
			rs = big_t'({1'b0, p.a_radius}) + big_t'({1'b0, p.b_radius});
			ca = vx * vx + vy * vy;
			cb = dx * vx + dy * vy;
			cc = dx * dx + dy * dy - rs * rs;
			e.status = scci_pkg::ST_HIT;
			e.entry_time = '0;
			e.exit_time = '0;
			if (ca == 0) begin
				e.status = scci_pkg::ST_STILL;
			end else begin
				disc = cb * cb - ca * cc;
				if (disc < 0) begin
					e.status = scci_pkg::ST_MISS;
				end else begin
					s = isqrt(disc <<< (2 * scci_pkg::FRAC_BITS));
					nb = -(cb <<< scci_pkg::FRAC_BITS);
					e.entry_time = floor_div_sat(nb - s, ca);
					e.exit_time = floor_div_sat(nb + s, ca);
				end
			end
			pending.push_back(e);
		endfunction

		function automatic void check_contact(scci_pkg::contact_t got);
			scci_pkg::contact_t e;
			if (pending.size() == 0) begin
				$error("contact word with nothing expected: status %0d", got.status);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.status !== e.status) begin
				$error("status expected %0d actual %0d", e.status, got.status);
				errors++;
			end
			if (got.entry_time !== e.entry_time) begin
				$error("entry_time expected %0d actual %0d", e.entry_time, got.entry_time);
				errors++;
			end
			if (got.exit_time !== e.exit_time) begin
				$error("exit_time expected %0d actual %0d", e.exit_time, got.exit_time);
				errors++;
			end
		endfunction
	endclass

	localparam int N_RANDOM = 650;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic pair_valid = 1'b0;
	logic pair_stall;
	scci_pkg::pair_t pair = '0;
	logic contact_valid;
	logic contact_stall = 1'b0;
	scci_pkg::contact_t contact;

	contact_board board = new();
	int cycles = 0;
	bit calm = 1'b0;    // a stretch with no idling on either side

	swept_circle_contact_interval dut (
		.clk(clk),
		.arst_n(arst_n),
		.pair_valid(pair_valid),
		.pair_stall(pair_stall),
		.pair(pair),
		.contact_valid(contact_valid),
		.contact_stall(contact_stall),
		.contact(contact)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Result side: check every accepted word and stall at random.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && contact_valid && !contact_stall)
			board.check_contact(contact);
		contact_stall <= !calm && ($urandom_range(99) < 18);
	end

	// Timeout guard.
	always @(posedge clk) begin
		if (cycles >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic logic signed [31:0] rnd_coord();
		case ($urandom_range(5))
			0: return 32'sh7FFFFFFF - $urandom_range(3);
			1: return 32'sh80000000 + $urandom_range(3);
			2: return $urandom;
			default: return $signed($urandom_range(2000000)) - 1000000;
		endcase
	endfunction

	function automatic logic [30:0] rnd_radius();
		case ($urandom_range(4))
			0: return 31'(32'h7FFFFFFF - $urandom_range(3));
			1: return 31'($urandom);
			default: return 31'($urandom_range(300000));
		endcase
	endfunction

	// Mostly nearby circles that may touch, sometimes full-range noise.
	function automatic scci_pkg::pair_t rnd_pair();
		scci_pkg::pair_t p;
		if ($urandom_range(3) == 0) begin
			p.a_start_x = rnd_coord();
			p.a_start_y = rnd_coord();
			p.a_end_x = rnd_coord();
			p.a_end_y = rnd_coord();
			p.b_start_x = rnd_coord();
			p.b_start_y = rnd_coord();
			p.b_end_x = rnd_coord();
			p.b_end_y = rnd_coord();
			p.a_radius = rnd_radius();
			p.b_radius = rnd_radius();
		end else begin
			p.a_start_x = $signed($urandom_range(4000000)) - 2000000;
			p.a_start_y = $signed($urandom_range(4000000)) - 2000000;
			p.a_end_x = p.a_start_x + $signed($urandom_range(1000000)) - 500000;
			p.a_end_y = p.a_start_y + $signed($urandom_range(1000000)) - 500000;
			p.b_start_x = $signed($urandom_range(4000000)) - 2000000;
			p.b_start_y = $signed($urandom_range(4000000)) - 2000000;
			p.b_end_x = p.b_start_x + $signed($urandom_range(1000000)) - 500000;
			p.b_end_y = p.b_start_y + $signed($urandom_range(1000000)) - 500000;
			p.a_radius = 31'($urandom_range(1000000));
			p.b_radius = 31'($urandom_range(1000000));
			// Occasionally identical motion, so no relative movement.
			if ($urandom_range(15) == 0) begin
				p.b_end_x = p.b_start_x + (p.a_end_x - p.a_start_x);
				p.b_end_y = p.b_start_y + (p.a_end_y - p.a_start_y);
			end
		end
		return p;
	endfunction

	// Present one word, hold it until accepted, with random gaps before it.
	task automatic send_pair(scci_pkg::pair_t p);
		while (!calm && $urandom_range(99) < 18) begin
			pair_valid <= 1'b0;
			@(posedge clk);
		end
		pair_valid <= 1'b1;
		pair <= p;
		@(posedge clk);
		while (pair_stall)
			@(posedge clk);
		board.note_pair(p);
	endtask

	task automatic send_directed();
		scci_pkg::pair_t p;
		// Head-on approach along x: a clean hit inside the step.
		p = '0;
		p.b_start_x = 32'sd10 << 16;
		p.a_radius = 31'd1 << 16;
		p.b_radius = 31'd1 << 16;
		send_pair(p);
		// Both circles standing still: no relative motion.
		p = '0;
		p.a_start_x = 32'sd5;
		p.a_end_x = 32'sd5;
		p.a_radius = 31'd7;
		send_pair(p);
		// Parallel motion far apart: a miss.
		p = '0;
		p.b_start_y = 32'sd100 << 16;
		p.b_end_y = 32'sd100 << 16;
		p.b_end_x = 32'sd1 << 16;
		p.a_radius = 31'd1 << 16;
		send_pair(p);
		// Already overlapping: negative entry time.
		p = '0;
		p.b_end_x = 32'sd1 << 16;
		p.a_radius = 31'd4 << 16;
		send_pair(p);
		// Tiny relative motion with huge gap: the exit time saturates.
		p = '0;
		p.a_start_x = 32'sh80000000;
		p.a_end_x = 32'sh80000000;
		p.b_start_x = 32'sh7FFFFFFF;
		p.b_end_x = 32'sh7FFFFFFE;
		p.a_radius = 31'h7FFFFFFF;
		p.b_radius = 31'h7FFFFFFF;
		send_pair(p);
		// Grazing contact: zero discriminant.
		p = '0;
		p.b_start_x = 32'sd10;
		p.b_start_y = 32'sd2;
		p.b_end_y = 32'sd2;
		p.a_radius = 31'd1;
		p.b_radius = 31'd1;
		send_pair(p);
		// Extremes of every coordinate and radius.
		p = '0;
		p.a_start_x = 32'sh7FFFFFFF;
		p.a_start_y = 32'sh80000000;
		p.a_end_x = 32'sh80000000;
		p.a_end_y = 32'sh7FFFFFFF;
		p.b_start_x = 32'sh80000000;
		p.b_start_y = 32'sh7FFFFFFF;
		p.b_end_x = 32'sh7FFFFFFF;
		p.b_end_y = 32'sh80000000;
		p.a_radius = 31'h7FFFFFFF;
		send_pair(p);
		p = '1;
		send_pair(p);
		p.a_start_x = 32'sh80000000;
		p.b_end_y = 32'sh80000000;
		p.b_radius = '0;
		send_pair(p);
		for (int i = 0; i < 10; i++) begin
			p = rnd_pair();
			send_pair(p);
		end
	endtask

	initial begin
		int drain;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_directed();
		for (int i = 0; i < N_RANDOM; i++) begin
			// A burst with no idling in the middle of the run.
			calm = (i >= 250 && i < 350);
			send_pair(rnd_pair());
		end
		calm = 1'b0;
		pair_valid <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
		drain = 0;
		while (drain < DRAIN_CYCLES) begin
			@(posedge clk);
			drain++;
		end
		if (board.errors == 0 && board.pending.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
